[rtl/core/shsc_pkg.sv]
// Shared types and constants for the staged heater session controller.
// No dependencies; imported by every module of the block.
package shsc_pkg;

	localparam int HEATER_STAGES = 4;
	localparam int SECONDS_W     = 14;
	localparam int WARMUP_W      = 9;
	localparam int CFG_INDEX_W   = 3;
	localparam int CFG_DATA_W    = 9;

	typedef logic [HEATER_STAGES-1:0] heater_mask_t;

	// Item modes
	localparam logic [1:0] MODE_TICK      = 2'd0;
	localparam logic [1:0] MODE_POWER_ON  = 2'd1;
	localparam logic [1:0] MODE_POWER_OFF = 2'd2;

	// Register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_TARGET_TEMP     = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SESSION_MINUTES = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_WARMUP_SECONDS  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_WARMUP_TEMP     = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_ADJUST_INTERVAL = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_BAND_ONE        = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_BAND_TWO        = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_BAND_THREE      = 3'd7;

	// Heater stage patterns
	localparam heater_mask_t MASK_OFF   = 4'b0000;
	localparam heater_mask_t MASK_ONE   = 4'b0001;
	localparam heater_mask_t MASK_TWO   = 4'b0011;
	localparam heater_mask_t MASK_THREE = 4'b0111;
	localparam heater_mask_t MASK_ALL   = 4'b1111;
	localparam heater_mask_t MASK_HALF  = 4'b0101;

	typedef struct packed {
		logic [6:0] target_temp;
		logic [7:0] session_minutes;
		logic [8:0] warmup_seconds;
		logic [6:0] warmup_temp;
		logic [7:0] adjust_interval;
		logic [6:0] band_one;
		logic [6:0] band_two;
		logic [6:0] band_three;
	} cfg_t;

	typedef struct packed {
		logic                 warmed;
		logic                 powered;
		logic                 latched;
		logic [SECONDS_W-1:0] session_remaining;
		logic [SECONDS_W-1:0] session_total;
		logic [WARMUP_W-1:0]  warmup_remaining;
		logic [7:0]           adjust_count;
		heater_mask_t         heater;
	} state_t;

	typedef struct packed {
		logic [1:0]        mode;
		logic signed [7:0] temperature;
	} item_t;

	typedef struct packed {
		heater_mask_t         heater_mask;
		logic                 warming;
		logic                 powered;
		logic [SECONDS_W-1:0] seconds_left;
		logic [WARMUP_W-1:0]  warmup_left;
		logic [SECONDS_W-1:0] elapsed_seconds;
		logic                 shutdown_event;
	} result_t;

	localparam cfg_t CFG_RESET = '{
		target_temp:     7'd60,
		session_minutes: 8'd45,
		warmup_seconds:  9'd30,
		warmup_temp:     7'd40,
		adjust_interval: 8'd10,
		band_one:        7'd1,
		band_two:        7'd4,
		band_three:      7'd7
	};

	localparam state_t STATE_RESET = '{
		warmed:            1'b0,
		powered:           1'b1,
		latched:           1'b0,
		session_remaining: 14'd2700,
		session_total:     14'd2700,
		warmup_remaining:  9'd30,
		adjust_count:      8'd0,
		heater:            MASK_OFF
	};

endpackage

[rtl/core/shsc_cfg.sv]
// Configuration register file of the staged heater session controller.
// Depends on shsc_pkg.
module shsc_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wen,
	input  logic [shsc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [shsc_pkg::CFG_DATA_W-1:0]  cfg_data,
	output shsc_pkg::cfg_t                   cfg
);
	import shsc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_TARGET_TEMP:     cfg_q.target_temp     <= cfg_data[6:0];
				REG_SESSION_MINUTES: cfg_q.session_minutes <= cfg_data[7:0];
				REG_WARMUP_SECONDS:  cfg_q.warmup_seconds  <= cfg_data[8:0];
				REG_WARMUP_TEMP:     cfg_q.warmup_temp     <= cfg_data[6:0];
				REG_ADJUST_INTERVAL: cfg_q.adjust_interval <= cfg_data[7:0];
				REG_BAND_ONE:        cfg_q.band_one        <= cfg_data[6:0];
				REG_BAND_TWO:        cfg_q.band_two        <= cfg_data[6:0];
				REG_BAND_THREE:      cfg_q.band_three      <= cfg_data[6:0];
				default:             cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[rtl/core/shsc_step.sv]
// Single-pass step logic: next session state and result for one item.
// Depends on shsc_pkg.
module shsc_step (
	input  shsc_pkg::cfg_t    cfg,
	input  shsc_pkg::state_t  cur,
	input  shsc_pkg::item_t   item,
	output shsc_pkg::state_t  nxt,
	output shsc_pkg::result_t res
);
	import shsc_pkg::*;

	logic signed [8:0]    temp9;
	logic signed [8:0]    tgt9;
	logic signed [8:0]    warm9;
	logic [8:0]           over_v;
	logic [8:0]           under_v;
	logic [8:0]           count_inc;
	logic [7:0]           interval;
	logic [SECONDS_W-1:0] minutes_x60;
	logic                 shut;

	always_comb begin
		temp9       = {item.temperature[7], item.temperature};
		tgt9        = $signed({2'b00, cfg.target_temp});
		warm9       = $signed({2'b00, cfg.warmup_temp});
		over_v      = temp9 - tgt9;
		under_v     = tgt9 - temp9;
		count_inc   = {1'b0, cur.adjust_count} + 9'd1;
		interval    = (cfg.adjust_interval == 8'd0) ? 8'd1 : cfg.adjust_interval;
		// times 60 as times 64 minus times 4
		minutes_x60 = ({6'd0, cfg.session_minutes} << 6) - ({6'd0, cfg.session_minutes} << 2);
		shut        = 1'b0;
		nxt         = cur;

		case (item.mode)
			MODE_POWER_ON: begin
				nxt.session_total     = minutes_x60;
				nxt.session_remaining = minutes_x60;
				nxt.warmup_remaining  = cfg.warmup_seconds;
				nxt.warmed            = 1'b0;
				nxt.powered           = 1'b1;
			end
			MODE_POWER_OFF: begin
				nxt.powered           = 1'b0;
				nxt.session_remaining = '0;
			end
			MODE_TICK: begin
				if (!cur.warmed)
					nxt.warmed = (cur.warmup_remaining == '0) || (temp9 >= warm9);

				if (!nxt.warmed) begin
					if (cur.warmup_remaining != '0)
						nxt.warmup_remaining = cur.warmup_remaining - 9'd1;
				end else if (cur.powered && cur.session_remaining != '0) begin
					nxt.session_remaining = cur.session_remaining - 14'd1;
				end

				if (nxt.session_remaining == '0) begin
					shut        = cur.powered;
					nxt.powered = 1'b0;
				end

				if (count_inc >= {1'b0, interval}) begin
					nxt.adjust_count = '0;
					if (nxt.warmed && !nxt.powered) begin
						nxt.heater = MASK_OFF;
					end else begin
						if (!cur.latched) begin
							nxt.latched = (temp9 >= tgt9);
							nxt.heater  = MASK_ALL;
						end
						if (nxt.latched && temp9 > tgt9) begin
							nxt.heater = (over_v < {2'b00, cfg.band_two}) ? MASK_HALF : MASK_OFF;
						end else if (nxt.latched && temp9 < tgt9) begin
							if (under_v <= {2'b00, cfg.band_one})
								nxt.heater = MASK_ONE;
							else if (under_v <= {2'b00, cfg.band_two})
								nxt.heater = MASK_TWO;
							else if (under_v <= {2'b00, cfg.band_three})
								nxt.heater = MASK_THREE;
							else
								nxt.heater = MASK_ALL;
						end
					end
				end else begin
					nxt.adjust_count = count_inc[7:0];
				end
			end
			default: nxt = cur;
		endcase

		res.heater_mask     = nxt.heater;
		res.warming         = !nxt.warmed;
		res.powered         = nxt.powered;
		res.seconds_left    = nxt.session_remaining;
		res.warmup_left     = nxt.warmup_remaining;
		res.elapsed_seconds = (nxt.session_remaining <= nxt.session_total)
		                      ? (nxt.session_total - nxt.session_remaining) : '0;
		res.shutdown_event  = shut;
	end

endmodule

[rtl/core/staged_heater_session_controller.sv]
// Top level of the staged heater session controller.
// Depends on shsc_pkg, shsc_cfg and shsc_step.

// Thermostat for a four-stage heater with a timed session. Each transfer on
// the input channel is a one-second tick with the measured temperature, or a
// power-on or power-off command; each one yields exactly one result transfer
// with the heater drive mask and the session status. The block sustains one
// item per clock while the result channel is not stalled: a transfer lands
// in an input register, the step logic reads it together with the session
// state combinationally, writes the state back and loads the result register
// at the same edge, so the next item always sees the updated state. out_valid
// rises once the item has moved from the input register to the result
// register. The input side keeps accepting while a finished result waits at
// the output, until the input register is also full. Write configuration only
// while no item is in flight; registers take effect on the next tick.
module staged_heater_session_controller (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration writes
	input  logic                                  cfg_wen,
	input  logic [shsc_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [shsc_pkg::CFG_DATA_W-1:0]       cfg_data,
	// input channel
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [1:0]                            mode,
	input  logic signed [7:0]                     temperature,
	// result channel
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [shsc_pkg::HEATER_STAGES-1:0]    heater_mask,
	output logic                                  warming,
	output logic                                  powered,
	output logic [shsc_pkg::SECONDS_W-1:0]        seconds_left,
	output logic [shsc_pkg::WARMUP_W-1:0]         warmup_left,
	output logic [shsc_pkg::SECONDS_W-1:0]        elapsed_seconds,
	output logic                                  shutdown_event
);
	import shsc_pkg::*;

	cfg_t    cfg;
	state_t  state_q;
	state_t  state_nxt;
	item_t   item_s1;
	logic    valid_s1;
	result_t result_nxt;
	result_t result_s2;
	logic    valid_s2;
	logic    load_s2;
	logic    take_s1;

	shsc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	shsc_step u_step (
		.cfg  (cfg),
		.cur  (state_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (result_nxt)
	);

	// Result register loads when empty or drained this cycle; the input
	// register advances whenever its item moves on.
	assign load_s2  = !valid_s2 || out_ready;
	assign take_s1  = valid_s1 && load_s2;
	assign in_ready = !valid_s1 || load_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= STATE_RESET;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (load_s2)
				valid_s2 <= valid_s1;
			// commit session state as each item leaves the input register
			if (take_s1)
				state_q <= state_nxt;
		end
	end

	// payload registers: hold until the next transfer
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.mode        <= mode;
			item_s1.temperature <= temperature;
		end
		if (take_s1)
			result_s2 <= result_nxt;
	end

	assign out_valid       = valid_s2;
	assign heater_mask     = result_s2.heater_mask;
	assign warming         = result_s2.warming;
	assign powered         = result_s2.powered;
	assign seconds_left    = result_s2.seconds_left;
	assign warmup_left     = result_s2.warmup_left;
	assign elapsed_seconds = result_s2.elapsed_seconds;
	assign shutdown_event  = result_s2.shutdown_event;

`ifndef SYNTHESIS
	// remaining session time never exceeds the loaded total
	a_remaining_within_total: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.session_remaining <= state_q.session_total)
		else $error("session remaining exceeds session total");

	// a shutdown result always reports power off with no time left
	a_shutdown_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && shutdown_event |-> !powered && seconds_left == '0)
		else $error("shutdown result inconsistent with power status");

	// once the target is reached, the latch stays set
	a_latch_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.latched |=> state_q.latched)
		else $error("target latch cleared");

	// a stalled item in the input register is neither lost nor altered
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !load_s2 |=> valid_s1 && $stable(item_s1) && $stable(state_q))
		else $error("stalled input item or state changed");
`endif

endmodule
